// File: hdl/serial_topic_line_router_defines.svh
// Assertion helpers for the checker file.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef SERIAL_TOPIC_LINE_ROUTER_DEFINES_SVH
`define SERIAL_TOPIC_LINE_ROUTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/slr_pkg.sv
package slr_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MRD,
        S_MCMP,
        S_PRD,
        S_PCMP,
        S_ERD,
        S_EOUT
    } t_state;

    // Character codes.
    localparam logic [7:0] CHAR_LF        = 8'd10;
    localparam logic [7:0] CHAR_CR        = 8'd13;
    localparam logic [7:0] CHAR_SPACE     = 8'd32;
    localparam logic [7:0] CHAR_PLUS      = 8'd43;
    localparam logic [7:0] CHAR_MINUS     = 8'd45;
    localparam logic [7:0] CHAR_ZERO      = 8'd48;
    localparam logic [7:0] CHAR_NINE      = 8'd57;

    // Configuration map.
    localparam int          TOPIC_REGS      = 4;
    localparam int          TOPIC_W         = 64;
    localparam int          CFG_IDX_W       = 3;
    localparam int          TCOUNT_W        = 3;
    localparam logic [2:0]  CFG_TOPIC_COUNT = 3'd4;

    // Result packing.
    localparam int DATA_W        = 48;
    localparam int USER_W        = 4;
    localparam int NUM_W         = 32;
    localparam int LEN_W         = 5;
    localparam int DATA_NUM_LSB  = 7;
    localparam int DATA_OVF_BIT  = 39;
    localparam int DATA_LEN_LSB  = 40;
    localparam int USER_MATCHED  = 0;
    localparam int USER_VALID    = 3;

endpackage

// File: hdl/slr_ram.sv
module slr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/serial_topic_line_router.sv
// Channel  | Dir | Payload                                          | Handshake
// ---------+-----+--------------------------------------------------+-----------------------
// s_axis   | in  | tdata[7:0] rx_byte                               | tvalid/tready
// m_axis   | out | tdata payload/number/overflow/length, tuser flags| tvalid/tready, tlast
// i_cfg    | in  | i_cfg_idx selects topic 0..3 or topic count      | i_cfg_we, no wait
//
// A byte that does not end a line is transferred and stored, with input ready again.
// A line end runs the sequencer over the line store, whose registered read gives each
// step a read and a work state: MRD/MCMP per topic character compared (plus the trailing
// space), PRD/PCMP per sign or digit parsed, ERD/EOUT per payload byte sent; EOUT stalls.
// i_rst_n is synchronous, active low; it clears the state, fill count, output valid and config registers.
// The result register is separate from the input side: a new byte is taken while the
// last result of a line still waits for m_axis_tready.
module serial_topic_line_router #(
    parameter int LINE_BYTES  = 32,
    parameter int TOPIC_SLOTS = 4,
    parameter int TOPIC_CHARS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [slr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [slr_pkg::TOPIC_W-1:0]     i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] rx_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [6:0] payload_byte, [38:7] number_value, [39] number_overflow,
    // [44:40] line_length, [47:45] zero
    output logic [slr_pkg::DATA_W-1:0]      m_axis_tdata,
    // [0] matched, [2:1] topic_index, [3] byte_valid
    output logic [slr_pkg::USER_W-1:0]      m_axis_tuser,
    output logic                            m_axis_tlast
);

    localparam int DEPTH = LINE_BYTES - 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = $clog2(LINE_BYTES + TOPIC_CHARS);

    slr_pkg::t_state r_state, n_state;

    logic [slr_pkg::TOPIC_W-1:0]  r_topic [slr_pkg::TOPIC_REGS];
    logic [slr_pkg::TCOUNT_W-1:0] r_tcount;

    logic [CW-1:0]  r_count, n_count;
    logic [PW-1:0]  r_pos, n_pos;
    logic [PW-1:0]  r_start, n_start;
    logic [1:0]     r_ti, n_ti;
    logic           r_hit, n_hit;
    logic           r_none, n_none;
    logic           r_first, n_first;
    logic           r_neg, n_neg;
    logic [31:0]    r_wv, n_wv;
    logic [32:0]    r_mag, n_mag;

    logic                        r_mvalid, n_mvalid;
    logic [slr_pkg::DATA_W-1:0]  r_mdata, n_mdata;
    logic [slr_pkg::USER_W-1:0]  r_muser, n_muser;
    logic                        r_mlast, n_mlast;

    logic                            in_ok;
    logic                            storable;
    logic                            is_end;
    logic                            ram_we;
    logic [6:0]                      ram_rdata;
    logic [slr_pkg::TCOUNT_W-1:0]    slots;
    logic [7:0]                      lc;
    logic [7:0]                      tc;
    logic                            lc_digit;
    logic [36:0]                     mag_x10;
    logic [32:0]                     mag_sat;
    logic [31:0]                     wv_x10;
    logic                            ovf;
    logic [31:0]                     value;
    logic                            out_free;
    logic                            item_last;

    // Input side: ready only while waiting for bytes.
    assign s_axis_tready = (r_state == slr_pkg::S_IDLE);
    assign in_ok         = s_axis_tvalid && s_axis_tready;
    assign storable      = !s_axis_tdata[7] && (s_axis_tdata[6:5] != 2'b00);
    assign is_end        = (s_axis_tdata == slr_pkg::CHAR_LF) ||
                           (s_axis_tdata == slr_pkg::CHAR_CR);
    assign ram_we        = in_ok && storable && (r_count < CW'(DEPTH));

    // Line store: written at the fill count, read at the sequencer position.
    slr_ram #(
        .WIDTH (7),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (s_axis_tdata[6:0]),
        .i_raddr (r_pos[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Clamp the topic count to the slots that exist.
    assign slots = (r_tcount > slr_pkg::TCOUNT_W'(TOPIC_SLOTS)) ?
                   slr_pkg::TCOUNT_W'(TOPIC_SLOTS) : r_tcount;

    // Shared compare operands: line character and topic character at the position.
    assign lc = (r_pos < PW'(r_count)) ? {1'b0, ram_rdata} : 8'd0;
    assign tc = (r_pos < PW'(TOPIC_CHARS)) ?
                r_topic[r_ti][{r_pos[2:0], 3'b000} +: 8] : 8'd0;

    // Digit step: multiply by ten with shifts, saturate the magnitude.
    assign lc_digit = (lc >= slr_pkg::CHAR_ZERO) && (lc <= slr_pkg::CHAR_NINE);
    assign mag_x10  = ({4'd0, r_mag} << 3) + ({4'd0, r_mag} << 1) + 37'(lc[3:0]);
    assign mag_sat  = (mag_x10 > 37'h1_0000_0000) ? 33'h1_0000_0001 : mag_x10[32:0];
    assign wv_x10   = (r_wv << 3) + (r_wv << 1) + 32'(lc[3:0]);

    assign ovf   = r_neg ? (r_mag > 33'h0_8000_0000) : (r_mag > 33'h0_7FFF_FFFF);
    assign value = r_neg ? (32'd0 - r_wv) : r_wv;

    assign out_free  = !r_mvalid || m_axis_tready;
    assign item_last = r_none || ((r_pos + PW'(1)) >= PW'(r_count));

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_start  = r_start;
        n_ti     = r_ti;
        n_hit    = r_hit;
        n_none   = r_none;
        n_first  = r_first;
        n_neg    = r_neg;
        n_wv     = r_wv;
        n_mag    = r_mag;
        n_mvalid = r_mvalid;
        n_mdata  = r_mdata;
        n_muser  = r_muser;
        n_mlast  = r_mlast;

        // Drop the held result once it is taken.
        if (r_mvalid && m_axis_tready) begin
            n_mvalid = 1'b0;
        end

        unique case (r_state)
            slr_pkg::S_IDLE: begin
                if (in_ok) begin
                    if (ram_we) begin
                        n_count = r_count + CW'(1);
                    end
                    if (is_end) begin
                        n_ti    = 2'd0;
                        n_pos   = '0;
                        n_hit   = 1'b0;
                        n_none  = 1'b0;
                        n_first = 1'b1;
                        n_neg   = 1'b0;
                        n_wv    = '0;
                        n_mag   = '0;
                        if (slots == '0) begin
                            n_none  = 1'b1;
                            n_state = slr_pkg::S_EOUT;
                        end else begin
                            n_state = slr_pkg::S_MRD;
                        end
                    end
                end
            end
            slr_pkg::S_MRD: begin
                n_state = slr_pkg::S_MCMP;
            end
            slr_pkg::S_MCMP: begin
                priority if ((tc == lc) && (tc != 8'd0)) begin
                    n_pos   = r_pos + PW'(1);
                    n_state = slr_pkg::S_MRD;
                end else if ((tc == 8'd0) && (lc == slr_pkg::CHAR_SPACE)) begin
                    // Topic ended on a space: payload starts after it.
                    n_hit   = 1'b1;
                    n_pos   = r_pos + PW'(1);
                    n_start = r_pos + PW'(1);
                    n_state = slr_pkg::S_PRD;
                end else if (({1'b0, r_ti} + 3'd1) < slots) begin
                    n_ti    = r_ti + 2'd1;
                    n_pos   = '0;
                    n_state = slr_pkg::S_MRD;
                end else begin
                    n_none  = 1'b1;
                    n_state = slr_pkg::S_EOUT;
                end
            end
            slr_pkg::S_PRD: begin
                n_state = slr_pkg::S_PCMP;
            end
            slr_pkg::S_PCMP: begin
                priority if (r_first && (lc == slr_pkg::CHAR_PLUS)) begin
                    n_first = 1'b0;
                    n_pos   = r_pos + PW'(1);
                    n_state = slr_pkg::S_PRD;
                end else if (r_first && (lc == slr_pkg::CHAR_MINUS)) begin
                    n_first = 1'b0;
                    n_neg   = 1'b1;
                    n_pos   = r_pos + PW'(1);
                    n_state = slr_pkg::S_PRD;
                end else if (lc_digit) begin
                    n_first = 1'b0;
                    n_wv    = wv_x10;
                    n_mag   = mag_sat;
                    n_pos   = r_pos + PW'(1);
                    n_state = slr_pkg::S_PRD;
                end else begin
                    n_pos = r_start;
                    if (r_start < PW'(r_count)) begin
                        n_state = slr_pkg::S_ERD;
                    end else begin
                        n_none  = 1'b1;
                        n_state = slr_pkg::S_EOUT;
                    end
                end
            end
            slr_pkg::S_ERD: begin
                n_state = slr_pkg::S_EOUT;
            end
            slr_pkg::S_EOUT: begin
                if (out_free) begin
                    n_mvalid = 1'b1;
                    n_mlast  = item_last;
                    n_mdata  = {3'd0,
                                slr_pkg::LEN_W'(r_count),
                                item_last && r_hit && ovf,
                                (item_last && r_hit) ? value : 32'd0,
                                r_none ? 7'd0 : ram_rdata};
                    n_muser  = {!r_none, r_hit ? r_ti : 2'd0, r_hit};
                    if (item_last) begin
                        n_count = '0;
                        n_state = slr_pkg::S_IDLE;
                    end else begin
                        n_pos   = r_pos + PW'(1);
                        n_state = slr_pkg::S_ERD;
                    end
                end
            end
            default: begin
                n_state = slr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= slr_pkg::S_IDLE;
            r_count  <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_mvalid <= n_mvalid;
        end
    end

    // Sequencer working registers and result payload: no reset needed.
    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_start <= n_start;
        r_ti    <= n_ti;
        r_hit   <= n_hit;
        r_none  <= n_none;
        r_first <= n_first;
        r_neg   <= n_neg;
        r_wv    <= n_wv;
        r_mag   <= n_mag;
        r_mdata <= n_mdata;
        r_muser <= n_muser;
        r_mlast <= n_mlast;
    end

    // Configuration registers; writes beyond the map are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < slr_pkg::TOPIC_REGS; i++) begin
                r_topic[i] <= '0;
            end
            r_tcount <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx < slr_pkg::CFG_TOPIC_COUNT) begin
                r_topic[i_cfg_idx[1:0]] <= i_cfg_data;
            end else if (i_cfg_idx == slr_pkg::CFG_TOPIC_COUNT) begin
                r_tcount <= i_cfg_data[slr_pkg::TCOUNT_W-1:0];
            end
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;
    assign m_axis_tlast  = r_mlast;

endmodule

// File: hdl/slr_checker.sv
`include "serial_topic_line_router_defines.svh"

module slr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [7:0]                    s_axis_tdata,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [slr_pkg::DATA_W-1:0]    m_axis_tdata,
    input logic [slr_pkg::USER_W-1:0]    m_axis_tuser,
    input logic                          m_axis_tlast
);

    // An unmatched line gives a single empty closing item with no number.
    `SLR_ASSERT_SAME(a_nomatch_single, m_axis_tvalid && !m_axis_tuser[slr_pkg::USER_MATCHED], m_axis_tlast && !m_axis_tuser[slr_pkg::USER_VALID] && (m_axis_tdata[slr_pkg::DATA_NUM_LSB +: 33] == 33'd0), "unmatched line result malformed")

    // Items before the last carry a character and no number.
    `SLR_ASSERT_SAME(a_mid_item, m_axis_tvalid && !m_axis_tlast, m_axis_tuser[slr_pkg::USER_VALID] && (m_axis_tdata[slr_pkg::DATA_NUM_LSB +: 33] == 33'd0), "non-final item malformed")

    // A stalled result holds.
    `SLR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

    // A line end starts the sequencer, so input is held off next cycle.
    `SLR_ASSERT_NEXT(a_busy_after_end, s_axis_tvalid && s_axis_tready && ((s_axis_tdata == slr_pkg::CHAR_LF) || (s_axis_tdata == slr_pkg::CHAR_CR)), !s_axis_tready, "input ready right after line end")

endmodule

bind serial_topic_line_router slr_checker u_slr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: bench/tb_serial_topic_line_router.sv
module tb_serial_topic_line_router;
    timeunit 1ns;
    timeprecision 1ps;

    import slr_pkg::*;

    // Block parameters, kept at the values the block is built with.
    localparam int LINE_BYTES  = 32;
    localparam int TOPIC_SLOTS = 4;
    localparam int TOPIC_CHARS = 8;
    // Characters the line store holds before it drops further bytes.
    localparam int LINE_CAP    = LINE_BYTES - 2;

    localparam int CLK_PERIOD  = 20;

    // Register map: topics at 0..3, topic count at the package's index.
    localparam logic [CFG_IDX_W-1:0] REG_TOPIC_0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOPIC_COUNT = CFG_TOPIC_COUNT;

    // A line end walks up to four topics of nine characters, then the sign and digits;
    // wait_idle settles only after every owed transfer, before a register write.
    localparam int IDLE_SETTLE   = 16;
    localparam int END_SETTLE    = 200;
    // Length of the long receiver hold-off.
    localparam int HOLD_CYCLES   = 400;
    // Longest quiet stretch of a correct run is the hold-off plus one line end;
    // take that several times over.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASE_BYTES = 40;

    localparam logic [15:0] RX_STALL_MASK = 16'b1011_0111_1101_1110;

    typedef enum int {
        RX_STEADY,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_style;

    // One output transfer of the router, field by field.
    typedef struct packed {
        logic        matched;
        logic [1:0]  topic_index;
        logic [6:0]  payload_byte;
        logic        byte_valid;
        logic        last;
        logic [31:0] number_value;
        logic        number_overflow;
        logic [4:0]  line_length;
    } t_route_item;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [TOPIC_W-1:0]     i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;     // [7:0] rx_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [6:0] payload_byte, [38:7] number_value, [39] number_overflow, [44:40] line_length
    logic [DATA_W-1:0]      m_axis_tdata;
    // [0] matched, [2:1] topic_index, [3] byte_valid
    logic [USER_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    // Shadow of the router: its registers and the line being collected.
    logic [TOPIC_W-1:0]     cfg_topics [0:TOPIC_REGS-1];
    logic [TCOUNT_W-1:0]    cfg_topic_count;
    logic [6:0]             line_buf [0:LINE_BYTES-1];
    int                     line_len;
    // Output transfers still owed by the router, oldest first.
    t_route_item            routed_items [$];

    // Sender state.
    int  burst_left = 0;
    bit  sender_live = 1'b0;

    // Receiver state: a toggle from the test side starts the long hold-off.
    logic      hold_toggle = 1'b0;
    logic      hold_seen = 1'b0;
    int        rx_hold_left = 0;
    int        rx_style_left = 0;
    int        rx_pattern_pos = 0;
    t_rx_style rx_style = RX_STEADY;

    int mismatch_count = 0;
    int results_checked = 0;
    int bytes_sent = 0;
    int lines_ended = 0;
    int matched_lines = 0;
    int quiet_cycles = 0;

    serial_topic_line_router #(
        .LINE_BYTES  (LINE_BYTES),
        .TOPIC_SLOTS (TOPIC_SLOTS),
        .TOPIC_CHARS (TOPIC_CHARS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Router shadow. Store printable bytes while there is room; on CR or LF
    // match the line against the active topics, parse the payload's leading
    // number and queue the transfers the line should produce.
    // ------------------------------------------------------------------
    task automatic route_rx_byte(input logic [7:0] value);
        t_route_item item;
        int          slots, hit_idx, start, i, j, k, p, digit;
        bit          hit, stop, neg, ovf;
        logic [7:0]  tc, lc;
        logic [31:0] wrapped;
        logic [63:0] mag;

        if (line_len < LINE_CAP && value >= CHAR_SPACE && value <= 8'd127) begin
            line_buf[line_len] = value[6:0];
            line_len++;
        end
        if (value != CHAR_LF && value != CHAR_CR)
            return;

        // A count above the slot number checks every slot.
        slots = (int'(cfg_topic_count) > TOPIC_SLOTS) ? TOPIC_SLOTS : int'(cfg_topic_count);
        hit = 1'b0;
        hit_idx = 0;
        start = 0;
        for (i = 0; i < slots && !hit; i++) begin
            stop = 1'b0;
            // The topic ends at its first zero byte or after TOPIC_CHARS;
            // the line must carry a space exactly there.
            for (j = 0; j <= TOPIC_CHARS && !stop; j++) begin
                tc = (j < TOPIC_CHARS) ? cfg_topics[i][8*j +: 8] : 8'd0;
                lc = (j < line_len) ? {1'b0, line_buf[j]} : 8'd0;
                if (tc != lc) begin
                    stop = 1'b1;
                    if (tc == 8'd0 && lc == CHAR_SPACE) begin
                        hit = 1'b1;
                        hit_idx = i;
                        start = j + 1;
                    end
                end else if (tc == 8'd0) begin
                    stop = 1'b1;
                end
            end
        end

        // Optional sign, then digits; the value wraps at 32 bits while the
        // saturating magnitude decides overflow.
        neg = 1'b0;
        wrapped = '0;
        mag = '0;
        p = start;
        if (hit) begin
            if (p < line_len && line_buf[p] == CHAR_PLUS) begin
                p++;
            end else if (p < line_len && line_buf[p] == CHAR_MINUS) begin
                neg = 1'b1;
                p++;
            end
            while (p < line_len && line_buf[p] >= CHAR_ZERO && line_buf[p] <= CHAR_NINE) begin
                digit = line_buf[p] - CHAR_ZERO[6:0];
                wrapped = wrapped * 32'd10 + digit;
                mag = mag * 64'd10 + digit;
                if (mag > 64'h1_0000_0000)
                    mag = 64'h1_0000_0001;
                p++;
            end
        end
        ovf = neg ? (mag > 64'h8000_0000) : (mag > 64'h7FFF_FFFF);

        item = '0;
        item.line_length = 5'(line_len);
        if (hit && start < line_len) begin
            for (k = start; k < line_len; k++) begin
                item.matched = 1'b1;
                item.topic_index = 2'(hit_idx);
                item.payload_byte = line_buf[k];
                item.byte_valid = 1'b1;
                routed_items.push_back(item);
            end
            // The number rides on the final payload transfer.
            item = routed_items.pop_back();
        end else begin
            item.matched = hit;
            item.topic_index = hit ? 2'(hit_idx) : 2'd0;
        end
        item.last = 1'b1;
        item.number_value = hit ? (neg ? 32'd0 - wrapped : wrapped) : 32'd0;
        item.number_overflow = hit && ovf;
        routed_items.push_back(item);

        lines_ended++;
        if (hit)
            matched_lines++;
        line_len = 0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Write one register; call only while the router is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOPIC_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < TOPIC_REGS)
            cfg_topics[idx] = value;
        else if (idx == REG_TOPIC_COUNT)
            cfg_topic_count = value[TCOUNT_W-1:0];
        @(posedge i_clk);
    endtask

    // Offer one byte in the sender's burst pattern and wait for its transfer.
    // Valid stays high between bytes of a burst and drops at its end.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        sender_live = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        route_rx_byte(value);
        bytes_sent++;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            sender_live = 1'b0;
        end
    endtask

    task automatic send_line(input string text, input logic [7:0] ending);
        int i;
        for (i = 0; i < text.len(); i++)
            send_byte(text[i]);
        send_byte(ending);
    endtask

    // Drop valid, hold until every owed transfer has arrived, then settle.
    task automatic wait_idle(input int settle);
        if (sender_live) begin
            s_axis_tvalid <= 1'b0;
            sender_live = 1'b0;
        end
        burst_left = 0;
        while (routed_items.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic logic [TOPIC_W-1:0] pack_topic(input string text);
        logic [TOPIC_W-1:0] word;
        int i;
        word = '0;
        for (i = 0; i < text.len() && i < TOPIC_CHARS; i++)
            word[8*i +: 8] = text[i];
        return word;
    endfunction

    // Printable topic without spaces, between the given lengths.
    function automatic logic [TOPIC_W-1:0] random_topic(input int min_chars, input int max_chars);
        logic [TOPIC_W-1:0] word;
        int n, i;
        word = '0;
        n = $urandom_range(min_chars, max_chars);
        for (i = 0; i < n; i++)
            word[8*i +: 8] = 8'($urandom_range(33, 126));
        return word;
    endfunction

    // Mostly well-formed lines: a topic from one of the four registers
    // (active or not), a space, an optional sign and digits, a printable tail.
    // The rest is raw noise or bare line ends.
    task automatic send_random_line();
        logic [7:0]  line_q [$];
        logic [63:0] word;
        string       limit_text;
        int          kind, slot, n, i, sign;

        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            slot = $urandom_range(0, TOPIC_REGS - 1);
            word = cfg_topics[slot];
            for (i = 0; i < TOPIC_CHARS && word[8*i +: 8] != 8'd0; i++)
                line_q.push_back(word[8*i +: 8]);
            // Now and then leave the space out so the line equals the topic.
            if ($urandom_range(0, 7) != 0)
                line_q.push_back(CHAR_SPACE);
            sign = $urandom_range(0, 3);
            if (sign == 0)
                line_q.push_back(CHAR_PLUS);
            else if (sign == 1)
                line_q.push_back(CHAR_MINUS);
            if ($urandom_range(0, 5) == 0) begin
                // Values around the 32-bit limits.
                case ($urandom_range(0, 4))
                    0: limit_text = "2147483647";
                    1: limit_text = "2147483648";
                    2: limit_text = "2147483649";
                    3: limit_text = "4294967295";
                    default: limit_text = "4294967296";
                endcase
                for (i = 0; i < limit_text.len(); i++)
                    line_q.push_back(limit_text[i]);
            end else begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5);
                for (i = 0; i < n; i++)
                    line_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            // A long tail runs the line store past its capacity.
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 30) : $urandom_range(0, 6);
            for (i = 0; i < n; i++)
                line_q.push_back(8'($urandom_range(32, 127)));
        end else if (kind <= 8) begin
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++)
                line_q.push_back(8'($urandom_range(0, 255)));
        end

        case ($urandom_range(0, 2))
            0: line_q.push_back(CHAR_LF);
            1: line_q.push_back(CHAR_CR);
            default: begin
                line_q.push_back(CHAR_CR);
                line_q.push_back(CHAR_LF);
            end
        endcase
        for (i = 0; i < line_q.size(); i++)
            send_byte(line_q[i]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Two overlapping topics: signed numbers, empty payload, a line equal to
    // the topic, an empty line from CR LF, a lone sign and dropped bytes.
    task automatic test_line_basics();
        write_reg(REG_TOPIC_0, pack_topic("a"));
        write_reg(REG_TOPIC_0 + 3'd1, pack_topic("ab"));
        write_reg(REG_TOPIC_COUNT, 64'd2);
        send_line("a -12", CHAR_LF);
        send_line("ab +7x", CHAR_CR);
        send_line("a", CHAR_CR);
        send_byte(CHAR_LF);
        send_line("a ", CHAR_LF);
        send_line("a -", CHAR_CR);
        // Control and high bytes never reach the line store.
        send_byte(8'h07);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_line("a 1", CHAR_LF);
        wait_idle(IDLE_SETTLE);
    endtask

    // Empty topic, full-width topic, topic count above the slots and zero,
    // and a line that overruns the store.
    task automatic test_topic_edges();
        write_reg(REG_TOPIC_0, 64'd0);
        write_reg(REG_TOPIC_0 + 3'd1, pack_topic("abcdefgh"));
        write_reg(REG_TOPIC_COUNT, 64'd7);
        send_line(" 5", CHAR_LF);
        wait_idle(IDLE_SETTLE);

        write_reg(REG_TOPIC_0, pack_topic("q"));
        send_line("abcdefgh 42", CHAR_CR);
        send_line("q 123456789012345678901234567890xyz", CHAR_LF);
        wait_idle(IDLE_SETTLE);

        write_reg(REG_TOPIC_COUNT, 64'd0);
        send_line("q 1", CHAR_LF);
        wait_idle(IDLE_SETTLE);
    endtask

    // Hold the output off for a long stretch while lines keep arriving, so
    // the result register and sequencer fill and the input stalls.
    task automatic test_output_hold();
        write_reg(REG_TOPIC_0, pack_topic("t"));
        write_reg(REG_TOPIC_COUNT, 64'd1);
        hold_toggle <= ~hold_toggle;
        send_line("t 2147483648", CHAR_LF);
        send_line("t -2147483648 end", CHAR_CR);
        send_line("x", CHAR_LF);
        wait_idle(IDLE_SETTLE);
    endtask

    // Random lines under four register settings, from all printable topics
    // through raw and all-ones words to a single full-width topic.
    task automatic test_random_traffic();
        int phase, slot, first_byte;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    for (slot = 0; slot < TOPIC_REGS; slot++)
                        write_reg(CFG_IDX_W'(REG_TOPIC_0 + slot), random_topic(1, TOPIC_CHARS));
                    write_reg(REG_TOPIC_COUNT, 64'd4);
                end
                1: begin
                    write_reg(REG_TOPIC_0, '1);
                    write_reg(REG_TOPIC_0 + 3'd1, {$urandom, $urandom});
                    write_reg(REG_TOPIC_0 + 3'd2, 64'd0);
                    write_reg(REG_TOPIC_0 + 3'd3, random_topic(1, 3));
                    write_reg(REG_TOPIC_COUNT, 64'd7);
                end
                2: begin
                    write_reg(REG_TOPIC_0, random_topic(TOPIC_CHARS, TOPIC_CHARS));
                    write_reg(REG_TOPIC_COUNT, 64'd1);
                end
                default: begin
                    for (slot = 0; slot < TOPIC_REGS; slot++)
                        write_reg(CFG_IDX_W'(REG_TOPIC_0 + slot), random_topic(1, 4));
                    write_reg(REG_TOPIC_COUNT, 64'd3);
                end
            endcase
            first_byte = bytes_sent;
            while (bytes_sent - first_byte < RANDOM_PHASE_BYTES)
                send_random_line();
            wait_idle(IDLE_SETTLE);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: switch between always ready, random stalls and a fixed stall
    // mask in stretches of its own; a toggle starts the long hold-off.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            rx_hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_style_left == 0) begin
                rx_style = t_rx_style'($urandom_range(0, 2));
                rx_style_left = $urandom_range(16, 96);
            end else begin
                rx_style_left--;
            end
            rx_pattern_pos = (rx_pattern_pos + 1) % 16;
            case (rx_style)
                RX_STEADY: m_axis_tready <= 1'b1;
                RX_RANDOM: m_axis_tready <= ($urandom_range(0, 2) != 0);
                default:   m_axis_tready <= RX_STALL_MASK[rx_pattern_pos];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result check: compare every output transfer with the oldest owed item.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR transfer %0d, %s: got 0x%0h, expected 0x%0h",
                 results_checked, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_route_item got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.matched         = m_axis_tuser[USER_MATCHED];
            got.topic_index     = m_axis_tuser[USER_MATCHED + 1 +: 2];
            got.byte_valid      = m_axis_tuser[USER_VALID];
            got.payload_byte    = m_axis_tdata[6:0];
            got.number_value    = m_axis_tdata[DATA_NUM_LSB +: NUM_W];
            got.number_overflow = m_axis_tdata[DATA_OVF_BIT];
            got.line_length     = m_axis_tdata[DATA_LEN_LSB +: LEN_W];
            got.last            = m_axis_tlast;
            if (routed_items.size() == 0) begin
                report_mismatch("transfer with nothing owed", m_axis_tdata, '0);
            end else begin
                want = routed_items.pop_front();
                if (got.matched !== want.matched)
                    report_mismatch("matched", got.matched, want.matched);
                if (got.topic_index !== want.topic_index)
                    report_mismatch("topic_index", got.topic_index, want.topic_index);
                if (got.payload_byte !== want.payload_byte)
                    report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
                if (got.byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
                if (got.last !== want.last)
                    report_mismatch("tlast", got.last, want.last);
                if (got.number_value !== want.number_value)
                    report_mismatch("number_value", got.number_value, want.number_value);
                if (got.number_overflow !== want.number_overflow)
                    report_mismatch("number_overflow", got.number_overflow,
                                    want.number_overflow);
                if (got.line_length !== want.line_length)
                    report_mismatch("line_length", got.line_length, want.line_length);
            end
            results_checked++;
        end
    end

    // Watchdog: end the run when no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles, %0d items still owed",
                         quiet_cycles, routed_items.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed tests, hold-off, random traffic, drain.
    // ------------------------------------------------------------------
    initial begin
        int i;
        for (i = 0; i < TOPIC_REGS; i++)
            cfg_topics[i] = '0;
        cfg_topic_count = '0;
        line_len = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_line_basics();
        test_topic_edges();
        test_output_hold();
        test_random_traffic();
        wait_idle(END_SETTLE);

        $display("Run covered %0d received bytes and %0d line ends (%0d routed to a topic),",
                 bytes_sent, lines_ended, matched_lines);
        $display("%0d output transfers checked across empty, full-width, raw and all-ones topics.",
                 results_checked);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: serial_topic_line_router.f
+incdir+hdl
hdl/slr_pkg.sv
hdl/slr_ram.sv
hdl/serial_topic_line_router.sv
hdl/slr_checker.sv
bench/tb_serial_topic_line_router.sv
